[src/bmpd_pkg.sv]
// Shared types and constants for the 24-bit bitmap stream decoder.
package bmpd_pkg;

    // Default image dimension width (bits of width and height that are kept).
    localparam int DIM_BITS_DEF = 16;

    // Depth of the queue between the accepting front and the parsing back.
    // Must be a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Fixed header layout: byte index at which each field is complete.
    localparam logic [5:0] HB_MAGIC  = 6'd1;
    localparam logic [5:0] HB_SIZE   = 6'd17;
    localparam logic [5:0] HB_WIDTH  = 6'd21;
    localparam logic [5:0] HB_HEIGHT = 6'd25;
    localparam logic [5:0] HB_PLANES = 6'd27;
    localparam logic [5:0] HB_COMPR  = 6'd33;
    localparam logic [5:0] HB_LAST   = 6'd53;

    localparam logic [15:0] MAGIC_BM    = 16'h4D42;
    localparam logic [31:0] INFO_SIZE   = 32'd40;
    localparam logic [15:0] PLANES_ONE  = 16'd1;
    localparam logic [31:0] COMPR_NONE  = 32'd0;

    typedef enum logic [2:0] {
        STAT_PIXEL      = 3'd0,
        STAT_BAD_MAGIC  = 3'd1,
        STAT_BAD_SIZE   = 3'd2,
        STAT_BAD_PLANES = 3'd3,
        STAT_COMPRESSED = 3'd4,
        STAT_BAD_DIM    = 3'd5,
        STAT_EMPTY      = 3'd6
    } status_t;

    // One queued input beat.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       first;
    } q_item_t;

endpackage

[src/bmpd_front.sv]
// Front end: accepts input beats into a short register queue.
module bmpd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bmpd_pkg::q_item_t in_item,
    output logic              q_valid,
    output bmpd_pkg::q_item_t q_item,
    input  logic              q_pop
);

    localparam int DEPTH = bmpd_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    bmpd_pkg::q_item_t mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              push;
    logic              pop;

    assign in_stall = (cnt_reg == CW'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (!push && pop)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

[src/bmpd_back.sv]
// Back end: header check, pixel assembly, padding skip and output register.
module bmpd_back
#(
    parameter int DIM_BITS = bmpd_pkg::DIM_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  bmpd_pkg::q_item_t q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [15:0]       row,
    output logic [15:0]       column,
    output logic              last
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [5:0]            hc_reg, hc_next;
    logic [31:0]           fs_reg, fs_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [1:0]            pad_reg, pad_next;
    logic [1:0]            padc_reg, padc_next;
    logic [DIM_BITS-1:0]   row_reg, row_next;
    logic [DIM_BITS-1:0]   col_reg, col_next;
    logic [1:0]            ti_reg, ti_next;
    logic [7:0]            hblue_reg, hblue_next;
    logic [7:0]            hgreen_reg, hgreen_next;

    logic                  ov_reg, ov_next;
    bmpd_pkg::status_t     st_reg, st_next;
    logic [7:0]            r_reg, r_next;
    logic [7:0]            g_reg, g_next;
    logic [7:0]            b_reg, b_next;
    logic [15:0]           orow_reg, orow_next;
    logic [15:0]           ocol_reg, ocol_next;
    logic                  olast_reg, olast_next;

    // Per-beat working values
    phase_t                ph;
    logic [5:0]            hc;
    logic [31:0]           fs_new;
    logic                  has_res;
    bmpd_pkg::status_t     res_st;
    logic [7:0]            res_r;
    logic [7:0]            res_g;
    logic [7:0]            res_b;
    logic [15:0]           res_row;
    logic [15:0]           res_col;
    logic                  res_last;
    logic                  out_free;
    logic                  advance;
    logic                  col_end;

    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;
    assign row       = orow_reg;
    assign column    = ocol_reg;
    assign last      = olast_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        fs_next     = fs_reg;
        width_next  = width_reg;
        height_next = height_reg;
        pad_next    = pad_reg;
        padc_next   = padc_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        ti_next     = ti_reg;
        hblue_next  = hblue_reg;
        hgreen_next = hgreen_reg;

        has_res  = 1'b0;
        res_st   = bmpd_pkg::STAT_PIXEL;
        res_r    = '0;
        res_g    = '0;
        res_b    = '0;
        res_row  = '0;
        res_col  = '0;
        res_last = 1'b1;

        // first restarts the header parse before this beat is used
        ph     = q_item.first ? PH_HEADER : phase_reg;
        hc     = q_item.first ? 6'd0 : hc_reg;
        fs_new = {q_item.byte_val, (q_item.first ? 24'd0 : fs_reg[31:8])};
        if (q_item.first)
        begin
            ti_next = 2'd0;
        end
        col_end = (col_reg == width_reg - DIM_BITS'(1));

        unique case (ph)
            PH_HEADER:
            begin
                phase_next = PH_HEADER;
                fs_next    = fs_new;
                hc_next    = hc + 6'd1;
                priority if (hc == bmpd_pkg::HB_MAGIC && fs_new[31:16] != bmpd_pkg::MAGIC_BM)
                begin
                    has_res = 1'b1;
                    res_st  = bmpd_pkg::STAT_BAD_MAGIC;
                end
                else if (hc == bmpd_pkg::HB_SIZE && fs_new != bmpd_pkg::INFO_SIZE)
                begin
                    has_res = 1'b1;
                    res_st  = bmpd_pkg::STAT_BAD_SIZE;
                end
                else if (hc == bmpd_pkg::HB_WIDTH || hc == bmpd_pkg::HB_HEIGHT)
                begin
                    // negative or wider than DIM_BITS
                    if ((fs_new >> DIM_BITS) != 32'd0)
                    begin
                        has_res = 1'b1;
                        res_st  = bmpd_pkg::STAT_BAD_DIM;
                    end
                    else if (hc == bmpd_pkg::HB_WIDTH)
                    begin
                        width_next = fs_new[DIM_BITS-1:0];
                    end
                    else
                    begin
                        height_next = fs_new[DIM_BITS-1:0];
                    end
                end
                else if (hc == bmpd_pkg::HB_PLANES && fs_new[31:16] != bmpd_pkg::PLANES_ONE)
                begin
                    has_res = 1'b1;
                    res_st  = bmpd_pkg::STAT_BAD_PLANES;
                end
                else if (hc == bmpd_pkg::HB_COMPR && fs_new != bmpd_pkg::COMPR_NONE)
                begin
                    has_res = 1'b1;
                    res_st  = bmpd_pkg::STAT_COMPRESSED;
                end
                else if (hc == bmpd_pkg::HB_LAST)
                begin
                    // row length 3*w, so padding to a word is w mod 4
                    pad_next = width_reg[1:0];
                    if (width_reg == '0 || height_reg == '0)
                    begin
                        has_res = 1'b1;
                        res_st  = bmpd_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        phase_next = PH_PIXEL;
                        row_next   = height_reg - DIM_BITS'(1);
                        col_next   = '0;
                        ti_next    = 2'd0;
                        padc_next  = 2'd0;
                    end
                end
                else
                begin
                    has_res = 1'b0;
                end
                if (has_res)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_PIXEL:
            begin
                unique case (ti_reg)
                    2'd0:
                    begin
                        hblue_next = q_item.byte_val;
                        ti_next    = 2'd1;
                    end
                    2'd1:
                    begin
                        hgreen_next = q_item.byte_val;
                        ti_next     = 2'd2;
                    end
                    default:
                    begin
                        ti_next  = 2'd0;
                        has_res  = 1'b1;
                        res_st   = bmpd_pkg::STAT_PIXEL;
                        res_r    = q_item.byte_val;
                        res_g    = hgreen_reg;
                        res_b    = hblue_reg;
                        res_row  = 16'(row_reg);
                        res_col  = 16'(col_reg);
                        res_last = (row_reg == '0) && col_end;
                        if (col_end)
                        begin
                            col_next = '0;
                            if (pad_reg != 2'd0)
                            begin
                                phase_next = PH_PAD;
                                padc_next  = 2'd0;
                            end
                            else if (row_reg == '0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                row_next = row_reg - DIM_BITS'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + DIM_BITS'(1);
                        end
                    end
                endcase
            end
            PH_PAD:
            begin
                padc_next = padc_reg + 2'd1;
                if (padc_next >= pad_reg)
                begin
                    if (row_reg == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        row_next   = row_reg - DIM_BITS'(1);
                        phase_next = PH_PIXEL;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Output register: drains when taken, reloads in the same cycle
        out_free = !ov_reg || !out_stall;
        advance  = q_valid && (!has_res || out_free);
        q_pop    = advance;

        ov_next    = ov_reg && out_stall;
        st_next    = st_reg;
        r_next     = r_reg;
        g_next     = g_reg;
        b_next     = b_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        olast_next = olast_reg;

        if (advance && has_res)
        begin
            ov_next    = 1'b1;
            st_next    = res_st;
            r_next     = res_r;
            g_next     = res_g;
            b_next     = res_b;
            orow_next  = res_row;
            ocol_next  = res_col;
            olast_next = res_last;
        end

        if (!advance)
        begin
            phase_next  = phase_reg;
            hc_next     = hc_reg;
            fs_next     = fs_reg;
            width_next  = width_reg;
            height_next = height_reg;
            pad_next    = pad_reg;
            padc_next   = padc_reg;
            row_next    = row_reg;
            col_next    = col_reg;
            ti_next     = ti_reg;
            hblue_next  = hblue_reg;
            hgreen_next = hgreen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hc_reg     <= '0;
            fs_reg     <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            pad_reg    <= '0;
            padc_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            ti_reg     <= '0;
            hblue_reg  <= '0;
            hgreen_reg <= '0;
            ov_reg     <= 1'b0;
            st_reg     <= bmpd_pkg::STAT_PIXEL;
            r_reg      <= '0;
            g_reg      <= '0;
            b_reg      <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            fs_reg     <= fs_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            pad_reg    <= pad_next;
            padc_reg   <= padc_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            ti_reg     <= ti_next;
            hblue_reg  <= hblue_next;
            hgreen_reg <= hgreen_next;
            ov_reg     <= ov_next;
            st_reg     <= st_next;
            r_reg      <= r_next;
            g_reg      <= g_next;
            b_reg      <= b_next;
            orow_reg   <= orow_next;
            ocol_reg   <= ocol_next;
            olast_reg  <= olast_next;
        end
    end

endmodule

[src/bmp24_stream_decoder_unit.sv]
// Top level of the 24-bit bitmap stream decoder.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------------
//  byte    | in  | byte_valid/byte_stall | byte_in, first
//  pix     | out | pix_valid/pix_stall   | status, red, green, blue, row, column, last
//
// One byte beat per clock while not full; a pixel beat leaves every third pixel byte.
// A byte is registered in the queue, then its result in the pix_valid output register.
// Rate is set by the back-end parser: one byte per cycle unless a result stalls.
// rst_n clears queue pointers, parser state and the output valid; no clearing pass.
// pix_stall holds the output register; the 4-entry queue keeps accepting until full.
module bmp24_stream_decoder_unit
#(
    parameter int DIM_BITS = bmpd_pkg::DIM_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // byte stream
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_in,
    input  logic        first,

    // pixel / status results
    output logic        pix_valid,
    input  logic        pix_stall,
    output logic [2:0]  status,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [15:0] row,
    output logic [15:0] column,
    output logic        last
);

    bmpd_pkg::q_item_t in_item;
    bmpd_pkg::q_item_t q_item;
    logic              q_valid;
    logic              q_pop;

    assign in_item.byte_val = byte_in;
    assign in_item.first    = first;

    // Front: takes beats, buffers them so the parser can stall on its own.
    bmpd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_valid),
        .in_stall (byte_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: header checks, BGR gather, padding skip, registered result.
    bmpd_back
    #(
        .DIM_BITS (DIM_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (pix_valid),
        .out_stall (pix_stall),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .row       (row),
        .column    (column),
        .last      (last)
    );

endmodule

[src/bmpd_checker.sv]
// Port-level assertions for the bitmap stream decoder, bound to the top level.
module bmpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  byte_in,
    input logic        first,
    input logic        pix_valid,
    input logic        pix_stall,
    input logic [2:0]  status,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic [15:0] row,
    input logic [15:0] column,
    input logic        last
);

    // Error and empty-image beats always close the file.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && status != bmpd_pkg::STAT_PIXEL |-> last)
        else $error("status beat without last");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> status <= bmpd_pkg::STAT_EMPTY)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && status != bmpd_pkg::STAT_PIXEL |->
            red == 8'd0 && green == 8'd0 && blue == 8'd0 && row == 16'd0 && column == 16'd0)
        else $error("status beat carries pixel data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(status) && $stable(row)
            && $stable(column) && $stable(last))
        else $error("stalled result beat changed");

    // A stalled byte beat stays on the port unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_in) && $stable(first))
        else $error("stalled byte beat changed");

endmodule

bind bmp24_stream_decoder_unit bmpd_checker u_bmpd_checker (.*);

[dv/bmp24_decode_check.sv]
// Checker for the bitmap stream decoder: predicts pixel and status beats and compares them.
module bmp24_decode_check
    import bmpd_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  byte_in,
    input  logic        first,
    input  logic        pix_valid,
    input  logic        pix_stall,
    input  logic [2:0]  status,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [15:0] row,
    input  logic [15:0] column,
    input  logic        last,
    output int          fail_count,
    output int          expected_left
);

    localparam logic [31:0] DIM_LIMIT = 32'((64'd1 << DIM_BITS) - 64'd1);

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_PIXEL,
        PARSE_PAD,
        PARSE_DONE
    } parse_phase_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] row;
        logic [15:0] column;
        logic        last;
    } pix_result_t;

    parse_phase_t  phase;
    logic [5:0]    hdr_count;
    logic [31:0]   field_shift;
    logic [31:0]   img_width;
    logic [31:0]   img_height;
    logic [1:0]    pad_bytes;
    logic [1:0]    pad_count;
    logic [31:0]   cur_row;
    logic [31:0]   cur_col;
    logic [1:0]    triple_idx;
    logic [7:0]    held_blue;
    logic [7:0]    held_green;
    pix_result_t   pending_pixels[$];

    function automatic int field_mismatch(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [5:0]  idx;
        logic [1:0]  rem;
        logic        emit;
        logic        row_done;
        int          bad;
        pix_result_t res;
        pix_result_t want;
        if (!rst_n) begin
            phase = PARSE_HEADER;
            hdr_count = '0;
            field_shift = '0;
            img_width = '0;
            img_height = '0;
            pad_bytes = '0;
            pad_count = '0;
            cur_row = '0;
            cur_col = '0;
            triple_idx = '0;
            held_blue = '0;
            held_green = '0;
            pending_pixels.delete();
            fail_count <= 0;
            expected_left <= 0;
        end
        else begin
            emit = 1'b0;
            row_done = 1'b0;
            bad = 0;
            res = '0;
            if (byte_valid && !byte_stall) begin
                if (first) begin
                    phase = PARSE_HEADER;
                    hdr_count = '0;
                    field_shift = '0;
                    triple_idx = '0;
                end
                case (phase)
                    PARSE_HEADER:
                    begin
                        field_shift = {byte_in, field_shift[31:8]};
                        idx = hdr_count;
                        hdr_count = hdr_count + 6'd1;
                        res.last = 1'b1;
                        if (idx == HB_MAGIC && field_shift[31:16] != MAGIC_BM) begin
                            emit = 1'b1;
                            res.status = STAT_BAD_MAGIC;
                        end
                        else if (idx == HB_SIZE && field_shift != INFO_SIZE) begin
                            emit = 1'b1;
                            res.status = STAT_BAD_SIZE;
                        end
                        else if (idx == HB_WIDTH || idx == HB_HEIGHT) begin
                            if (field_shift[31] || field_shift > DIM_LIMIT) begin
                                emit = 1'b1;
                                res.status = STAT_BAD_DIM;
                            end
                            else if (idx == HB_WIDTH)
                                img_width = field_shift;
                            else
                                img_height = field_shift;
                        end
                        else if (idx == HB_PLANES && field_shift[31:16] != PLANES_ONE) begin
                            emit = 1'b1;
                            res.status = STAT_BAD_PLANES;
                        end
                        else if (idx == HB_COMPR && field_shift != COMPR_NONE) begin
                            emit = 1'b1;
                            res.status = STAT_COMPRESSED;
                        end
                        else if (idx == HB_LAST) begin
                            // rows are padded to a multiple of four bytes
                            rem = 2'(img_width[1:0] * 2'd3);
                            pad_bytes = 2'd0 - rem;
                            if (img_width == 0 || img_height == 0) begin
                                emit = 1'b1;
                                res.status = STAT_EMPTY;
                            end
                            else begin
                                phase = PARSE_PIXEL;
                                cur_row = img_height - 32'd1;
                                cur_col = '0;
                                triple_idx = '0;
                                pad_count = '0;
                            end
                        end
                        if (emit)
                            phase = PARSE_DONE;
                    end
                    PARSE_PIXEL:
                    begin
                        if (triple_idx == 2'd0) begin
                            held_blue = byte_in;
                            triple_idx = 2'd1;
                        end
                        else if (triple_idx == 2'd1) begin
                            held_green = byte_in;
                            triple_idx = 2'd2;
                        end
                        else begin
                            triple_idx = 2'd0;
                            emit = 1'b1;
                            res.status = STAT_PIXEL;
                            res.red = byte_in;
                            res.green = held_green;
                            res.blue = held_blue;
                            res.row = cur_row[15:0];
                            res.column = cur_col[15:0];
                            res.last = (cur_row == 0 && cur_col == img_width - 32'd1);
                            cur_col = cur_col + 32'd1;
                            if (cur_col >= img_width) begin
                                cur_col = '0;
                                if (pad_bytes != 0) begin
                                    phase = PARSE_PAD;
                                    pad_count = '0;
                                end
                                else
                                    row_done = 1'b1;
                            end
                        end
                    end
                    PARSE_PAD:
                    begin
                        pad_count = pad_count + 2'd1;
                        if (pad_count >= pad_bytes)
                            row_done = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (row_done) begin
                    if (cur_row == 0)
                        phase = PARSE_DONE;
                    else begin
                        cur_row = cur_row - 32'd1;
                        phase = PARSE_PIXEL;
                    end
                end
                if (emit)
                    pending_pixels.push_back(res);
            end

            if (pix_valid && !pix_stall) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected beat, expected none got status %0d row %0d col %0d",
                             $time, status, row, column);
                    bad = 1;
                end
                else begin
                    want = pending_pixels.pop_front();
                    bad += field_mismatch("status", 16'(want.status), 16'(status));
                    bad += field_mismatch("red", 16'(want.red), 16'(red));
                    bad += field_mismatch("green", 16'(want.green), 16'(green));
                    bad += field_mismatch("blue", 16'(want.blue), 16'(blue));
                    bad += field_mismatch("row", want.row, row);
                    bad += field_mismatch("column", want.column, column);
                    bad += field_mismatch("last", 16'(want.last), 16'(last));
                end
            end
            fail_count <= fail_count + bad;
            expected_left <= pending_pixels.size();
        end
    end

endmodule

[dv/tb_bmp24_stream_decoder_unit.sv]
// Testbench top for the bitmap stream decoder: clock, reset, byte stimulus, verdict.
module tb_bmp24_stream_decoder_unit;
    import bmpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int BYTE_TARGET = 1450;     // bytes the parser actually consumes
    localparam int HOLD_CYCLES = 64;       // long output back-pressure stretch

    // Kinds of bitmap file the generator produces.
    typedef enum int {
        FILE_PIXELS,
        FILE_EMPTY,
        FILE_BAD_MAGIC,
        FILE_BAD_SIZE,
        FILE_BAD_PLANES,
        FILE_COMPRESSED,
        FILE_BAD_WIDTH,
        FILE_BAD_HEIGHT,
        FILE_TALL,
        FILE_COUNT
    } file_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  byte_in;
    logic        first;
    logic        pix_valid;
    logic        pix_stall;
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] row;
    logic [15:0] column;
    logic        last;

    int fail_count;
    int expected_left;
    int send_idle_pct;
    int stall_pct;
    int live_bytes = 0;
    int cycle_count = 0;
    bit hold_armed = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bmp24_stream_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_in    (byte_in),
        .first      (first),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .status     (status),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .row        (row),
        .column     (column),
        .last       (last)
    );

    bmp24_decode_check decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_in       (byte_in),
        .first         (first),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .status        (status),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .row           (row),
        .column        (column),
        .last          (last),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_left);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Pixel side: random stall, plus one long hold once armed. The hold starts
    // on the first valid beat after arming so the decoder really backs up.
    initial
    begin
        bit saw_valid;
        int hold_left;
        pix_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            saw_valid = pix_valid;
            @(negedge clk);
            if (hold_armed && saw_valid)
            begin
                hold_armed = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                pix_stall = 1'b1;
                hold_left--;
            end
            else
                pix_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // One byte beat. Called at a falling edge, returns at the falling edge
    // after the beat was taken. Valid stays up into the next call, so
    // back-to-back beats never drop valid.
    task automatic send_beat(input logic [7:0] val, input logic restart, input bit counted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_in = val;
        first = restart;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        @(negedge clk);
        if (counted)
            live_bytes++;
    endtask

    // Sender pause: nothing offered until every expected beat has left,
    // then a wait for bytes still in flight that produce nothing.
    task automatic drain_results();
        byte_valid = 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Width or height outside the accepted range: negative, just past the
    // limit, all ones, or random with high bits set.
    function automatic logic [31:0] out_of_range_dim();
        case ($urandom_range(3))
            0: return 32'h8000_0000 | 32'($urandom);
            1: return (32'd1 << DIM_BITS_DEF) + 32'($urandom_range(0, 3));
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom) | (32'd1 << DIM_BITS_DEF);
        endcase
    endfunction

    // Builds one file of the given kind and streams it. Error files stop at
    // the failing field, sometimes with ignored trailing bytes.
    task automatic send_file(input file_kind_t kind);
        logic [7:0]  hdr [54];
        logic [31:0] width;
        logic [31:0] height;
        int          stop_at;
        int          junk;
        int          pad;
        int          pick;
        longint      total;
        longint      n_bytes;
        bit          has_pixels;
        foreach (hdr[h])
            hdr[h] = 8'($urandom);
        width = 32'($urandom_range(1, 9));
        height = 32'($urandom_range(1, 4));
        stop_at = int'(HB_LAST);
        has_pixels = 1'b0;
        case (kind)
            FILE_PIXELS:
            begin
                has_pixels = 1'b1;
                if ($urandom_range(9) == 0)
                    width = 32'($urandom_range(10, 24));
            end
            FILE_EMPTY:
            begin
                if ($urandom_range(1))
                begin
                    width = '0;
                    height = 32'($urandom_range(0, 65535));
                end
                else
                begin
                    width = 32'($urandom_range(1, 65535));
                    height = '0;
                end
            end
            FILE_BAD_MAGIC:  stop_at = int'(HB_MAGIC);
            FILE_BAD_SIZE:   stop_at = int'(HB_SIZE);
            FILE_BAD_PLANES: stop_at = int'(HB_PLANES);
            FILE_COMPRESSED: stop_at = int'(HB_COMPR);
            FILE_BAD_WIDTH:
            begin
                stop_at = int'(HB_WIDTH);
                width = out_of_range_dim();
            end
            FILE_BAD_HEIGHT:
            begin
                stop_at = int'(HB_HEIGHT);
                height = out_of_range_dim();
            end
            default:
            begin
                // huge image cut short: high row numbers or the widest row
                has_pixels = 1'b1;
                if ($urandom_range(1))
                begin
                    width = 32'($urandom_range(1, 4));
                    height = $urandom_range(1) ? 32'd65535 : 32'($urandom_range(256, 65535));
                end
                else
                begin
                    width = 32'd65535;
                    height = 32'($urandom_range(1, 3));
                end
            end
        endcase

        {hdr[1], hdr[0]} = MAGIC_BM;
        {hdr[17], hdr[16], hdr[15], hdr[14]} = INFO_SIZE;
        {hdr[21], hdr[20], hdr[19], hdr[18]} = width;
        {hdr[25], hdr[24], hdr[23], hdr[22]} = height;
        {hdr[27], hdr[26]} = PLANES_ONE;
        {hdr[33], hdr[32], hdr[31], hdr[30]} = COMPR_NONE;

        // break the field that this kind is about
        case (kind)
            FILE_BAD_MAGIC:
                hdr[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
            FILE_BAD_SIZE:
                if ($urandom_range(1))
                    {hdr[17], hdr[16], hdr[15], hdr[14]} = 32'd12;   // older core header
                else
                    hdr[14 + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
            FILE_BAD_PLANES:
                if ($urandom_range(1))
                    {hdr[27], hdr[26]} = 16'd0;
                else
                    hdr[26 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
            FILE_COMPRESSED:
                if ($urandom_range(1))
                    {hdr[33], hdr[32], hdr[31], hdr[30]} = 32'($urandom_range(1, 3));
                else
                    hdr[30 + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
            default:
            begin
            end
        endcase

        // now and then a good header is cut off by the next file
        if (kind == FILE_PIXELS && $urandom_range(19) == 0)
        begin
            pick = $urandom_range(2, 53);
            for (int i = 0; i < pick; i++)
                send_beat(hdr[i], i == 0, 1'b1);
            return;
        end

        for (int i = 0; i <= stop_at; i++)
            send_beat(hdr[i], i == 0, 1'b1);

        if (!has_pixels)
        begin
            // bytes after an error or empty image are dropped until first
            if ($urandom_range(2) == 0)
            begin
                junk = $urandom_range(1, 6);
                for (int i = 0; i < junk; i++)
                    send_beat(8'($urandom), 1'b0, 1'b0);
            end
            return;
        end

        pad = (4 - (int'(width) * 3) % 4) % 4;
        total = longint'(height) * (longint'(width) * 3 + pad);
        n_bytes = total;
        if (kind == FILE_TALL)
            n_bytes = $urandom_range(1, 40);
        else if ($urandom_range(9) == 0)
            n_bytes = $urandom_range(1, int'(total));
        for (longint i = 0; i < n_bytes; i++)
            send_beat(8'($urandom), 1'b0, 1'b1);
        if (n_bytes == total && $urandom_range(4) == 0)
        begin
            junk = $urandom_range(1, 5);
            for (int i = 0; i < junk; i++)
                send_beat(8'($urandom), 1'b0, 1'b0);
        end
    endtask

    initial
    begin
        int         base;
        int         target;
        int         r;
        file_kind_t kind;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_in = '0;
        first = 1'b0;
        send_idle_pct = 22;
        stall_pct = 55;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Parse starts in the header even without first; bad magic on byte 1.
        send_beat(8'h42, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        // Dropped: file already ended.
        send_beat(8'hFF, 1'b0, 1'b0);
        // All-ones magic with first.
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1);
        // A lone start byte, restarted by the next file mid-magic.
        send_beat(MAGIC_BM[7:0], 1'b1, 1'b1);
        // One file of every kind so each status shows up early.
        for (int k = 0; k < FILE_COUNT; k++)
            send_file(file_kind_t'(k));

        // the rest of the byte budget is split over the three idle phases
        base = live_bytes;
        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                send_idle_pct = 55;
                stall_pct = 22;
            end
            if (p == 2)
            begin
                // full rate both ways, with one long pixel-side hold
                send_idle_pct = 0;
                stall_pct = 0;
                hold_armed = 1'b1;
                send_file(FILE_PIXELS);
            end
            target = base + (BYTE_TARGET - base) * (p + 1) / 3;
            while (live_bytes < target)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    kind = FILE_PIXELS;
                else if (r < 52)
                    kind = FILE_EMPTY;
                else if (r < 59)
                    kind = FILE_BAD_MAGIC;
                else if (r < 66)
                    kind = FILE_BAD_SIZE;
                else if (r < 73)
                    kind = FILE_BAD_PLANES;
                else if (r < 80)
                    kind = FILE_COMPRESSED;
                else if (r < 86)
                    kind = FILE_BAD_WIDTH;
                else if (r < 92)
                    kind = FILE_BAD_HEIGHT;
                else
                    kind = FILE_TALL;
                send_file(kind);
            end
            drain_results();
        end

        repeat (6) @(posedge clk);
        if (fail_count == 0 && expected_left == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
